/* hw/rtl/tepd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepd_pkg
// Shared types and constants of the trace extremum and plateau detector.
// ----------------------------------------------------------------------------
package tepd_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int Y_W             = 32;
    localparam int IDX_W           = 16;
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [IDX_W-1:0] sample_index;
        logic             last_index;
    } res_t;

    // Up to two results per transaction, compacted into the low slot first.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

/* hw/rtl/trace_extremum_plateau_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_extremum_plateau_detector_top
// Emits indices of direction changes, plateau midpoints and end points of a
// stream of trace samples.
//
//   channel | direction | tdata               | tlast
//   s_      | in        | [31:0] y_value      | last_sample
//   m_      | out       | [15:0] sample_index | last_index
//
// One sample per cycle while s_tready is high; the decision settles in the cycle
// of the transaction and its results are registered into a 4-entry output queue.
// A sample with two results occupies two output transfers; samples with
// at most one result sustain one sample per cycle while m_tready stays high.
// s_tready drops while fewer than two queue entries are free.
// aresetn clears the sample history, index counter and queue.
// ----------------------------------------------------------------------------
module trace_extremum_plateau_detector_top #(
    parameter int MAX_SAMPLES = tepd_pkg::MAX_SAMPLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] y_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample_index
    output logic        m_tlast
);
    import tepd_pkg::*;

    logic  in_accept;
    push_t push;
    res_t  out_res;
    logic  has_room;

    assign s_tready  = has_room;
    assign in_accept = s_tvalid && has_room;

    tepd_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .y_value     (signed'(s_tdata)),
        .last_sample (s_tlast),
        .push        (push)
    );

    tepd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.sample_index;
    assign m_tlast = out_res.last_index;

endmodule

/* hw/rtl/tepd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepd_core
// Sample history, index counter and turning point decision; emits up to two
// results for every accepted sample.
// ----------------------------------------------------------------------------
module tepd_core #(
    parameter int MAX_SAMPLES = tepd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_accept,
    input  logic signed [tepd_pkg::Y_W-1:0]     y_value,
    input  logic                                last_sample,
    output tepd_pkg::push_t                     push
);
    import tepd_pkg::*;

    localparam logic [IDX_W-1:0] IDX_TOP =
        ((MAX_SAMPLES - 1) > 65535) ? {IDX_W{1'b1}} : IDX_W'(MAX_SAMPLES - 1);

    logic signed [Y_W-1:0] older_reg, older_next;
    logic signed [Y_W-1:0] newer_reg, newer_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic                  full_reg, full_next;
    logic                  flat_reg, flat_next;
    logic [IDX_W-1:0]      start_reg, start_next;

    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] center_idx;
    logic [IDX_W-1:0] prev_idx;
    logic [IDX_W-1:0] run_begin;
    logic [IDX_W-1:0] mid_idx;
    logic             flat_eff;
    logic             emit0;
    logic [IDX_W-1:0] idx0;
    res_t             fin_res;

    always_comb begin
        cur_idx    = full_reg ? IDX_TOP : count_reg;
        center_idx = full_reg ? IDX_TOP : count_reg - IDX_W'(1);
        prev_idx   = full_reg ? IDX_TOP : count_reg - IDX_W'(2);
        flat_eff   = flat_reg || (older_reg == newer_reg);
        run_begin  = flat_reg ? start_reg : prev_idx;
        mid_idx    = run_begin + ((center_idx - run_begin) >> 1);

        emit0      = 1'b0;
        idx0       = '0;
        flat_next  = flat_reg;
        start_next = start_reg;

        if (!full_reg && count_reg == '0) begin
            emit0 = 1'b1;
        end else if (full_reg || count_reg >= IDX_W'(2)) begin
            if (flat_eff) begin
                start_next = run_begin;
                if (newer_reg != y_value) begin
                    flat_next = 1'b0;
                    if (run_begin != '0) begin
                        emit0 = 1'b1;
                        idx0  = mid_idx;
                    end
                end else begin
                    flat_next = 1'b1;
                end
            end else if ((older_reg < newer_reg && y_value < newer_reg) ||
                         (older_reg > newer_reg && y_value > newer_reg)) begin
                emit0 = 1'b1;
                idx0  = center_idx;
            end
        end

        older_next = newer_reg;
        newer_next = y_value;
        count_next = count_reg;
        full_next  = full_reg;
        if (last_sample) begin
            older_next = '0;
            newer_next = '0;
            count_next = '0;
            full_next  = 1'b0;
            flat_next  = 1'b0;
            start_next = '0;
        end else if (!full_reg) begin
            if (count_reg >= IDX_TOP) begin
                full_next = 1'b1;
            end else begin
                count_next = count_reg + IDX_W'(1);
            end
        end

        fin_res.sample_index = cur_idx;
        fin_res.last_index   = 1'b1;

        push.cnt    = 2'(emit0) + 2'(last_sample);
        push.second = fin_res;
        if (emit0) begin
            push.first.sample_index = idx0;
            push.first.last_index   = 1'b0;
        end else begin
            push.first = fin_res;
        end
        if (!in_accept) begin
            push.cnt = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
            full_reg  <= 1'b0;
            flat_reg  <= 1'b0;
            start_reg <= '0;
        end else if (in_accept) begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            full_reg  <= full_next;
            flat_reg  <= flat_next;
            start_reg <= start_next;
        end
    end

endmodule

/* hw/rtl/tepd_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepd_out_fifo
// Result register queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tepd_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  tepd_pkg::push_t push,
    output logic            has_room,
    output logic            out_valid,
    input  logic            out_ready,
    output tepd_pkg::res_t  out_res
);
    import tepd_pkg::*;

    res_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign out_valid  = (cnt_reg != '0);
    assign out_res    = mem_reg[rd_ptr_reg];
    assign has_room   = (cnt_reg <= (PTR_W+1)'(FIFO_DEPTH - 2));
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + (PTR_W+1)'(push.cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

/* hw/rtl/tepd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module tepd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    logic trace_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trace_start_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            trace_start_reg <= m_tlast;
        end
    end

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("stalled sample changed");

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && trace_start_reg |-> m_tdata == 16'd0 && !m_tlast)
        else $error("trace does not open with index 0");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind trace_extremum_plateau_detector_top tepd_checker u_tepd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
